// ----- hdl/dad_pkg.sv -----
// ----------------------------------------------------------------------------
// dad_pkg
// Shared constants and helpers for the Gregorian date plus day count block:
// field widths, calendar constants and the month length table.
// ----------------------------------------------------------------------------
package dad_pkg;

	// field widths
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 20;

	// running day remainder: day + months before + count stays below 2^21
	localparam int unsigned REM_W   = 21;
	// year counted one bit wider than the field so it never wraps inside
	localparam int unsigned YCNT_W  = YEAR_W + 1;
	// year residue modulo 400, wide enough to hold a whole input year
	localparam int unsigned R400_W  = YEAR_W;

	// calendar constants
	localparam logic [8:0]        YEAR_DAYS  = 9'd365;
	localparam logic [R400_W-1:0] CYCLE_LAST = R400_W'(399);
	localparam logic [R400_W-1:0] CENT_1     = R400_W'(100);
	localparam logic [R400_W-1:0] CENT_2     = R400_W'(200);
	localparam logic [R400_W-1:0] CENT_3     = R400_W'(300);
	localparam logic [REM_W-1:0]  CYCLE_DAYS = REM_W'(400);
	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	// binary reduction of the year modulo 400 runs 400<<5 down to 400<<0
	localparam logic [2:0] MOD_STEPS_LAST = 3'd5;

	// month length, month zero counts nothing, months above twelve act as december
	function automatic logic [DAY_W-1:0] month_len(
		input logic [MONTH_W-1:0] m,
		input logic               leap
	);
		logic [DAY_W-1:0] d;
		case (m)
			4'd0:    d = 5'd0;
			4'd1:    d = 5'd31;
			4'd2:    d = 5'd28;
			4'd3:    d = 5'd31;
			4'd4:    d = 5'd30;
			4'd5:    d = 5'd31;
			4'd6:    d = 5'd30;
			4'd7:    d = 5'd31;
			4'd8:    d = 5'd31;
			4'd9:    d = 5'd30;
			4'd10:   d = 5'd31;
			4'd11:   d = 5'd30;
			default: d = 5'd31;
		endcase
		if (m == MONTH_FEB) begin
			d = d + {4'd0, leap};
		end
		return d;
	endfunction

endpackage

// ----- hdl/dad_in_if.sv -----
// ----------------------------------------------------------------------------
// dad_in_if
// Input channel: start date and day count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dad_in_if;
	logic                         valid;
	logic                         ready;
	logic [dad_pkg::YEAR_W-1:0]   start_year;
	logic [dad_pkg::MONTH_W-1:0]  start_month;
	logic [dad_pkg::DAY_W-1:0]    start_day;
	logic [dad_pkg::COUNT_W-1:0]  days_to_add;

	modport source (
		output valid, start_year, start_month, start_day, days_to_add,
		input  ready
	);
	modport sink (
		input  valid, start_year, start_month, start_day, days_to_add,
		output ready
	);
endinterface

// ----- hdl/dad_out_if.sv -----
// ----------------------------------------------------------------------------
// dad_out_if
// Output channel: resulting date with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dad_out_if;
	logic                         valid;
	logic                         ready;
	logic [dad_pkg::YEAR_W-1:0]   end_year;
	logic [dad_pkg::MONTH_W-1:0]  end_month;
	logic [dad_pkg::DAY_W-1:0]    end_day;

	modport source (
		output valid, end_year, end_month, end_day,
		input  ready
	);
	modport sink (
		input  valid, end_year, end_month, end_day,
		output ready
	);
endinterface

// ----- hdl/date_add_days_top.sv -----
// ----------------------------------------------------------------------------
// date_add_days_top
// Gregorian date plus a non-negative day count, one shared adder under a
// small sequencer.
// ----------------------------------------------------------------------------
// One item at a time: din is ready only while the block is idle. Each item
// passes the modulo reduction, the months before the start (at most 12),
// the add of the count, the year loop, the month walk and the hold in
// dout. The year loop dominates: one 21-bit add/subtract unit removes one
// year of 365 or 366 days per cycle. The year modulo 400 is worked out
// first in six conditional subtract steps and then stepped alongside the
// year, which gives the leap test without a divider. The result is held in
// dout until taken, then the block goes idle.
module date_add_days_top (
	input  logic              clk,
	input  logic              arst_n,
	dad_in_if.sink            din,
	dad_out_if.source         dout
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_PRE,
		ST_YEAR,
		ST_MON,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [dad_pkg::YCNT_W-1:0]     year_q;
	logic [dad_pkg::R400_W-1:0]     r400_q;
	logic [dad_pkg::REM_W-1:0]      rem_q;
	logic [dad_pkg::COUNT_W-1:0]    count_q;
	logic [dad_pkg::MONTH_W-1:0]    before_q;
	logic [dad_pkg::MONTH_W-1:0]    m_q;
	logic [2:0]                     k_q;
	logic                           out_valid_q;
	logic [dad_pkg::YEAR_W-1:0]     end_year_q;
	logic [dad_pkg::MONTH_W-1:0]    end_month_q;
	logic [dad_pkg::DAY_W-1:0]      end_day_q;

	logic                           leap;
	logic [dad_pkg::DAY_W-1:0]      mlen;
	logic [8:0]                     ylen;
	logic [dad_pkg::MONTH_W-1:0]    before_in;
	logic [dad_pkg::REM_W-1:0]      op_a;
	logic [dad_pkg::REM_W-1:0]      op_b;
	logic                           op_sub;
	logic [dad_pkg::REM_W:0]        alu;
	logic                           alu_neg;
	logic                           alu_gt;
	logic                           pre_more;
	logic                           mon_more;
	logic [dad_pkg::R400_W-1:0]     r400_next;

	// leap test from the residue modulo 400 (mod 4 is its low bits)
	assign leap = (r400_q == '0) ||
		((r400_q[1:0] == 2'd0) && (r400_q != dad_pkg::CENT_1) &&
		 (r400_q != dad_pkg::CENT_2) && (r400_q != dad_pkg::CENT_3));

	assign mlen      = dad_pkg::month_len(m_q, leap);
	assign ylen      = dad_pkg::YEAR_DAYS + {8'd0, leap};
	assign pre_more  = (m_q <= before_q);
	assign r400_next = (r400_q == dad_pkg::CYCLE_LAST) ? '0 : r400_q + 1'b1;

	// months before the start month, saturated at twelve
	always_comb begin
		if (din.start_month == '0) begin
			before_in = '0;
		end else if (din.start_month > dad_pkg::MONTH_DEC) begin
			before_in = dad_pkg::MONTH_DEC;
		end else begin
			before_in = din.start_month - 1'b1;
		end
	end

	// operand selection for the shared add/subtract unit
	always_comb begin
		op_a   = rem_q;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			ST_MOD: begin
				op_a   = dad_pkg::REM_W'(r400_q);
				op_b   = dad_pkg::CYCLE_DAYS << k_q;
				op_sub = 1'b1;
			end
			ST_PRE: begin
				op_b   = pre_more ? dad_pkg::REM_W'(mlen) : dad_pkg::REM_W'(count_q);
				op_sub = 1'b0;
			end
			ST_YEAR: begin
				op_b   = dad_pkg::REM_W'(ylen);
				op_sub = 1'b1;
			end
			ST_MON: begin
				op_b   = dad_pkg::REM_W'(mlen);
				op_sub = 1'b1;
			end
			default: begin
				op_b   = '0;
				op_sub = 1'b0;
			end
		endcase
	end

	// shared unit, the sign bit of a difference doubles as the compare
	assign alu      = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
	assign alu_neg  = alu[dad_pkg::REM_W];
	assign alu_gt   = !alu_neg && (alu != '0);
	assign mon_more = (m_q < dad_pkg::MONTH_DEC) && alu_gt;

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			year_q      <= '0;
			r400_q      <= '0;
			rem_q       <= '0;
			count_q     <= '0;
			before_q    <= '0;
			m_q         <= dad_pkg::MONTH_JAN;
			k_q         <= '0;
			end_year_q  <= '0;
			end_month_q <= '0;
			end_day_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						year_q   <= {1'b0, din.start_year};
						r400_q   <= din.start_year;
						rem_q    <= dad_pkg::REM_W'(din.start_day);
						count_q  <= din.days_to_add;
						before_q <= before_in;
						m_q      <= dad_pkg::MONTH_JAN;
						k_q      <= dad_pkg::MOD_STEPS_LAST;
						state_q  <= ST_MOD;
					end
				end
				// reduce the start year modulo 400, one scaled subtract a cycle
				ST_MOD: begin
					if (!alu_neg) begin
						r400_q <= alu[dad_pkg::R400_W-1:0];
					end
					if (k_q == '0) begin
						state_q <= ST_PRE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				// add lengths of the months before the start, then the count
				ST_PRE: begin
					rem_q <= alu[dad_pkg::REM_W-1:0];
					if (pre_more) begin
						m_q <= m_q + 1'b1;
					end else begin
						state_q <= ST_YEAR;
					end
				end
				// peel off one whole year per cycle
				ST_YEAR: begin
					if (alu_gt) begin
						rem_q  <= alu[dad_pkg::REM_W-1:0];
						year_q <= year_q + 1'b1;
						r400_q <= r400_next;
					end else begin
						m_q     <= dad_pkg::MONTH_JAN;
						state_q <= ST_MON;
					end
				end
				// walk january to november, the rest lands in december
				ST_MON: begin
					if (mon_more) begin
						rem_q <= alu[dad_pkg::REM_W-1:0];
						m_q   <= m_q + 1'b1;
					end else begin
						end_year_q  <= year_q[dad_pkg::YEAR_W-1:0];
						end_month_q <= m_q;
						end_day_q   <= rem_q[dad_pkg::DAY_W-1:0];
						out_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end
				end
				// hold the result until the item is taken
				ST_DONE: begin
					if (dout.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	// channel outputs
	assign din.ready      = (state_q == ST_IDLE);
	assign dout.valid     = out_valid_q;
	assign dout.end_year  = end_year_q;
	assign dout.end_month = end_month_q;
	assign dout.end_day   = end_day_q;

endmodule

// ----- tb/date_add_days_checker.sv -----
// ----------------------------------------------------------------------------
// date_add_days_checker
// Watches both channels of the date plus day count block. Each start date
// taken in is turned into the date it should produce, and each date handed
// out is compared, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module date_add_days_checker
	import dad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	dad_in_if           din,
	dad_out_if          dout,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked,
	output int unsigned wrapped
);

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct {
		date_t               start;
		logic [COUNT_W-1:0]  count;
		date_t               due;
	} due_date_t;

	// days per month, index zero counts nothing, february without leap day
	localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned COMMON_YEAR     = 365;
	localparam int unsigned REPORT_LIMIT    = 10;

	due_date_t   due_dates [$];
	int unsigned n_fail;
	int unsigned n_checked;
	int unsigned n_wrapped;

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// months above twelve read as december
	function automatic int unsigned month_days(input int unsigned m, input bit leap);
		int unsigned d;
		d = MONTH_DAYS[(m > 12) ? 12 : m];
		if (m == 2) begin
			d = d + leap;
		end
		return d;
	endfunction

	// date reached after cnt days, year kept at full width until the end
	function automatic date_t date_after(input date_t start, input logic [COUNT_W-1:0] cnt);
		int unsigned yr;
		int unsigned remain;
		int unsigned months_before;
		int unsigned mon;
		bit          leap;
		date_t       res;
		yr     = start.year;
		remain = start.day;
		leap   = leap_year(yr);
		months_before = (start.month == 0) ? 0 : start.month - 1;
		if (months_before > 12) begin
			months_before = 12;
		end
		for (mon = 1; mon <= months_before; mon++) begin
			remain += month_days(mon, leap);
		end
		remain += cnt;
		// strip whole years
		while (remain > COMMON_YEAR + leap_year(yr)) begin
			remain -= COMMON_YEAR + leap_year(yr);
			yr++;
		end
		// walk january to november, the rest lands in december
		leap = leap_year(yr);
		mon  = 1;
		while (mon < 12 && remain > month_days(mon, leap)) begin
			remain -= month_days(mon, leap);
			mon++;
		end
		res.year  = YEAR_W'(yr);
		res.month = MONTH_W'(mon);
		res.day   = DAY_W'(remain);
		return res;
	endfunction

	function automatic void note_failure(input string what);
		if (n_fail < REPORT_LIMIT) begin
			$display("[%0t] %s", $realtime, what);
		end
		n_fail++;
	endfunction

	// track items in, compare items out
	always @(posedge clk or negedge arst_n) begin
		due_date_t entry;
		date_t     got;
		if (!arst_n) begin
			due_dates.delete();
			n_fail     = 0;
			n_checked  = 0;
			n_wrapped  = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			wrapped    <= 0;
		end else begin
			if (din.valid && din.ready) begin
				entry.start = '{year: din.start_year, month: din.start_month, day: din.start_day};
				entry.count = din.days_to_add;
				entry.due   = date_after(entry.start, entry.count);
				if (entry.due.year < entry.start.year) begin
					n_wrapped++;
				end
				due_dates.push_back(entry);
			end
			if (dout.valid && dout.ready) begin
				got = '{year: dout.end_year, month: dout.end_month, day: dout.end_day};
				if (due_dates.size() == 0) begin
					note_failure($sformatf("unexpected result %0d-%0d-%0d",
						got.year, got.month, got.day));
				end else begin
					entry = due_dates.pop_front();
					n_checked++;
					if (got.year != entry.due.year || got.month != entry.due.month ||
							got.day != entry.due.day) begin
						note_failure($sformatf(
							"mismatch: %0d-%0d-%0d + %0d days gave %0d-%0d-%0d, expected %0d-%0d-%0d",
							entry.start.year, entry.start.month, entry.start.day, entry.count,
							got.year, got.month, got.day,
							entry.due.year, entry.due.month, entry.due.day));
					end
				end
			end
			fail_count <= n_fail;
			pending    <= due_dates.size();
			checked    <= n_checked;
			wrapped    <= n_wrapped;
		end
	end

endmodule

// ----- tb/date_add_days_top_tb.sv -----
// ----------------------------------------------------------------------------
// date_add_days_top_tb
// Drives start dates and day counts into the date plus day count block with
// random gaps and output stalls, including a long output hold-off and a full
// drain pause. A directed set covers calendar edges, leap rules, off-calendar
// start dates and year wrap; the rest is random. The checker judges results.
// ----------------------------------------------------------------------------
module date_add_days_top_tb;
	import dad_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 200;
	localparam int unsigned LONG_HOLD_AT  = 30;
	localparam int unsigned LONG_HOLD     = 8000;
	localparam int unsigned DRAIN_AT      = 120;
	localparam int unsigned DRAIN_CYCLES  = 3000;
	localparam int unsigned CYCLE_LIMIT   = 3000000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int unsigned LONG_COUNT    = 100000;

	logic clk;
	logic arst_n;

	dad_in_if  din ();
	dad_out_if dout ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned wrapped;

	bit          quiet;
	int unsigned n_sent;
	int unsigned n_directed;
	int unsigned n_long;
	int unsigned n_odd;
	int unsigned cycles;

	date_add_days_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	date_add_days_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.dout       (dout),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.wrapped    (wrapped)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("date_add_days_top_tb: errors");
			$finish;
		end
	end

	// offer one item after a random gap, none while quiet, return at the edge it is taken
	task automatic send_date(
		input logic [YEAR_W-1:0]  y,
		input logic [MONTH_W-1:0] mo,
		input logic [DAY_W-1:0]   d,
		input logic [COUNT_W-1:0] cnt
	);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid       <= 1'b1;
		din.start_year  <= y;
		din.start_month <= mo;
		din.start_day   <= d;
		din.days_to_add <= cnt;
		do @(posedge clk); while (!din.ready);
		n_sent++;
		if (cnt > LONG_COUNT) begin
			n_long++;
		end
		if (mo == 0 || mo > 12 || d == 0) begin
			n_odd++;
		end
	endtask

	// result side: random stalls, one long hold-off, quiet stretches
	initial begin
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		dout.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (taken == LONG_HOLD_AT) begin
				stall = LONG_HOLD;
			end else if (quiet) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 12);
			end
			if (stall > 0) begin
				dout.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout.ready <= 1'b1;
			do @(posedge clk); while (!dout.valid);
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] mo;
		logic [DAY_W-1:0]   d;
		logic [COUNT_W-1:0] cnt;
		quiet      = 1'b0;
		n_sent     = 0;
		n_long     = 0;
		n_odd      = 0;
		cycles     = 0;
		arst_n     = 1'b0;
		din.valid       <= 1'b0;
		din.start_year  <= '0;
		din.start_month <= '0;
		din.start_day   <= '0;
		din.days_to_add <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: calendar edges, leap rules, off-calendar dates, wrap
		send_date(14'd2024, 4'd1, 5'd1, 20'd0);
		send_date(14'd1, 4'd1, 5'd1, 20'd0);
		send_date(14'd1, 4'd1, 5'd0, 20'd0);          // day zero in january
		send_date(14'd0, 4'd0, 5'd0, 20'd0);          // month zero, year zero
		send_date(14'd0, 4'd2, 5'd29, 20'd0);         // year zero is leap
		send_date(14'd2023, 4'd12, 5'd31, 20'd1);
		send_date(14'd2024, 4'd2, 5'd28, 20'd1);
		send_date(14'd1900, 4'd2, 5'd28, 20'd1);      // century, not leap
		send_date(14'd2000, 4'd2, 5'd28, 20'd1);      // 400-year leap
		send_date(14'd2023, 4'd2, 5'd31, 20'd0);      // day past month end
		send_date(14'd2023, 4'd15, 5'd31, 20'd0);     // month above twelve
		send_date(14'd2023, 4'd13, 5'd1, 20'd0);
		send_date(14'd2023, 4'd14, 5'd0, 20'd100);
		send_date(14'd9999, 4'd12, 5'd31, 20'd1);
		send_date(14'd9999, 4'd12, 5'd31, COUNT_MAX);
		send_date(14'd16383, 4'd12, 5'd31, COUNT_MAX); // year wraps
		send_date(14'd16383, 4'd12, 5'd31, 20'd1);
		send_date(14'd1, 4'd1, 5'd1, COUNT_MAX);
		send_date(14'd2024, 4'd6, 5'd15, 20'd365);
		send_date(14'd2023, 4'd11, 5'd30, 20'd31);    // spill into december
		send_date(14'd0, 4'd15, 5'd31, COUNT_MAX);
		send_date(14'd16383, 4'd0, 5'd31, 20'd0);
		send_date(14'd2100, 4'd3, 5'd1, 20'd0);
		send_date(14'd400, 4'd12, 5'd31, 20'd366);
		n_directed = n_sent;

		// random dates, counts spread over small to full range
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 60 && i < 90) || (i >= 160 && i < 180);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: y = YEAR_W'($urandom_range(1, 9999));
				12, 13, 14: y = YEAR_W'($urandom_range(0, 16383));
				15, 16:     y = YEAR_W'($urandom_range(0, 99) * 100);
				17:         y = YEAR_W'($urandom_range(16000, 16383));
				18:         y = '0;
				default:    y = YEAR_W'($urandom_range(0, 2499) * 4);
			endcase
			mo = ($urandom_range(0, 4) == 0) ? MONTH_W'($urandom_range(0, 15))
				: MONTH_W'($urandom_range(1, 12));
			d  = ($urandom_range(0, 4) == 0) ? DAY_W'($urandom_range(0, 31))
				: DAY_W'($urandom_range(1, 31));
			case ($urandom_range(0, 3))
				0:       cnt = COUNT_W'($urandom_range(0, 40));
				1:       cnt = COUNT_W'($urandom_range(0, 800));
				2:       cnt = COUNT_W'($urandom_range(0, 100000));
				default: cnt = COUNT_W'($urandom_range(0, 1048575));
			endcase
			send_date(y, mo, d, cnt);
			// let the block drain completely once
			if (i == DRAIN_AT) begin
				din.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
		end
		quiet = 1'b0;

		// drain
		din.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d items (%0d directed), %0d results checked, %0d counts over %0d days",
			n_sent, n_directed, checked, n_long, LONG_COUNT);
		$display("summary: %0d off-calendar start dates, %0d end years wrapped past 16383",
			n_odd, wrapped);
		if (fail_count == 0 && pending == 0) begin
			$display("date_add_days_top_tb: clean");
		end else begin
			$display("date_add_days_top_tb: errors");
		end
		$finish;
	end

endmodule
